>>> design/edmf_pkg.sv
// edmf_pkg: shared constants and helpers for the echo distance median filter
// holds field widths, configuration register codes, reset values and the median helper
// no dependencies
package edmf_pkg;

  // field widths
  localparam int TofW    = 16;
  localparam int DistW   = 11;
  localparam int CfgIdxW = 3;
  localparam int SlotW   = 2;

  // window depth is fixed at three entries per sensor
  localparam int WindowDepth = 3;

  // default sensor count
  localparam int SensorCountDefault = 2;

  // configuration register codes
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_S0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET_S1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_VALID = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_VALID = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NO_ECHO   = 3'd4;

  // item kinds
  localparam logic KIND_ECHO  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // configuration reset values
  localparam logic [DistW-1:0] MIN_VALID_RST = 11'd2;
  localparam logic [DistW-1:0] MAX_VALID_RST = 11'd320;
  localparam logic [DistW-1:0] NO_ECHO_RST   = 11'd999;

  // cm = floor(tof * 343 / 20000) = floor(tof * RECIP_C >> RECIP_SHIFT)
  // RECIP_C = ceil(2^31 * 343 / 20000), exact for every 16-bit time of flight
  localparam int ProdW       = 42;
  localparam int RECIP_SHIFT = 31;
  localparam logic [ProdW-1:0] RECIP_C = 42'd36829345;

  // window slot codes
  localparam logic [SlotW-1:0] SLOT_FIRST = 2'd0;
  localparam logic [SlotW-1:0] SLOT_LAST  = 2'd2;

  // middle value of three
  function automatic logic [DistW-1:0] mid_of_three(
    input logic [DistW-1:0] a,
    input logic [DistW-1:0] b,
    input logic [DistW-1:0] c
  );
    logic [DistW-1:0] lo;
    logic [DistW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      mid_of_three = lo;
    end else if (c >= hi) begin
      mid_of_three = hi;
    end else begin
      mid_of_three = c;
    end
  endfunction

endpackage

>>> design/echo_distance_median_filter_unit.sv
// echo_distance_median_filter_unit: per-sensor echo distance conversion and median filter
// converts time of flight to cm, range-qualifies, median-of-three filters, offsets, tracks minimum
// depends on edmf_pkg
//
// result path: input register, then result register
// throughput: one item per cycle unless out_ready stalls; the window and minimum update is one
// pass of logic behind the input register, after one constant multiply for the cm conversion
// reset (rst_n low, synchronous): windows and write slots cleared, minimums and
// configuration set to their defaults (no-echo 999, min 2, max 320, offsets 0)
module echo_distance_median_filter_unit
  import edmf_pkg::*;
#(
  parameter int SENSOR_COUNT = SensorCountDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic               in_sensor_id,
  input  logic [TofW-1:0]    in_echo_time_us,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_sensor,
  output logic [DistW-1:0]   out_qualified_cm,
  output logic [DistW-1:0]   out_filtered_cm,
  output logic [DistW-1:0]   out_interval_min_cm,
  output logic               out_in_range,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DistW-1:0]   cfg_data
);

  localparam int SidW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  // configuration registers
  logic [DistW-1:0] offset_s0_r;
  logic [DistW-1:0] offset_s1_r;
  logic [DistW-1:0] min_valid_r;
  logic [DistW-1:0] max_valid_r;
  logic [DistW-1:0] no_echo_r;

  // per-sensor state
  logic [DistW-1:0] window_r [SENSOR_COUNT][WindowDepth];
  logic [SlotW-1:0] slot_r   [SENSOR_COUNT];
  logic [DistW-1:0] min_r    [SENSOR_COUNT];

  // input register
  logic             s1_valid_r;
  logic             s1_kind_r;
  logic             s1_sid_r;
  logic [TofW-1:0]  s1_tof_r;

  // result register
  logic             out_valid_r;
  logic             out_sensor_r;
  logic [DistW-1:0] out_qual_r;
  logic [DistW-1:0] out_filt_r;
  logic [DistW-1:0] out_min_r;
  logic             out_in_range_r;

  // datapath signals
  logic             out_free;
  logic             s1_drop;
  logic             s1_fire;
  logic             s1_emit;
  logic [SidW-1:0]  sidx;
  logic [ProdW-1:0] prod;
  logic [DistW-1:0] dist_cm;
  logic             in_rng;
  logic [DistW-1:0] qual;
  logic [SlotW-1:0] slot_cur;
  logic [SlotW-1:0] slot_nxt;
  logic [DistW-1:0] win_nxt [WindowDepth];
  logic [DistW-1:0] med;
  logic [DistW-1:0] off;
  logic [DistW-1:0] filt;
  logic [DistW-1:0] min_old;
  logic [DistW-1:0] min_nxt;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_s0_r <= '0;
      offset_s1_r <= '0;
      min_valid_r <= MIN_VALID_RST;
      max_valid_r <= MAX_VALID_RST;
      no_echo_r   <= NO_ECHO_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OFFSET_S0: offset_s0_r <= cfg_data;
        CFG_OFFSET_S1: offset_s1_r <= cfg_data;
        CFG_MIN_VALID: min_valid_r <= cfg_data;
        CFG_MAX_VALID: max_valid_r <= cfg_data;
        CFG_NO_ECHO:   no_echo_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: echo items for absent sensors leave without a result
  assign out_free = !out_valid_r || out_ready;
  assign s1_drop  = (s1_kind_r == KIND_ECHO) && (int'(s1_sid_r) >= SENSOR_COUNT);
  assign s1_fire  = s1_valid_r && (out_free || s1_drop);
  assign s1_emit  = s1_fire && !s1_drop;
  assign in_ready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_sid_r  <= in_sensor_id;
      s1_tof_r  <= in_echo_time_us;
    end
  end

  assign sidx = SidW'(s1_sid_r);

  // time of flight to cm by reciprocal multiply
  assign prod    = ProdW'(s1_tof_r) * RECIP_C;
  assign dist_cm = prod[RECIP_SHIFT +: DistW];

  // range qualification
  assign in_rng = (dist_cm >= min_valid_r) && (dist_cm < max_valid_r);
  assign qual   = in_rng ? dist_cm : no_echo_r;

  // write slot advance, unused code falls back to the first slot
  always_comb begin
    slot_cur = (slot_r[sidx] > SLOT_LAST) ? SLOT_FIRST : slot_r[sidx];
    slot_nxt = (slot_cur == SLOT_LAST) ? SLOT_FIRST : slot_cur + 2'd1;
  end

  // write new value, raise smaller entries to it
  always_comb begin
    for (int i = 0; i < WindowDepth; i++) begin
      if (SlotW'(i) == slot_cur) begin
        win_nxt[i] = qual;
      end else if (window_r[sidx][i] < qual) begin
        win_nxt[i] = qual;
      end else begin
        win_nxt[i] = window_r[sidx][i];
      end
    end
  end

  // median and offset correction
  always_comb begin
    med = mid_of_three(win_nxt[0], win_nxt[1], win_nxt[2]);
    off = (s1_sid_r == 1'b0) ? offset_s0_r : offset_s1_r;
    if (med == no_echo_r) begin
      filt = no_echo_r;
    end else if (med > off) begin
      filt = med - off;
    end else begin
      filt = '0;
    end
  end

  // running minimum of non-zero results
  assign min_old = min_r[sidx];
  assign min_nxt = ((filt != '0) && (filt < min_old)) ? filt : min_old;

  // per-sensor state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        slot_r[s] <= SLOT_FIRST;
        min_r[s]  <= NO_ECHO_RST;
        for (int i = 0; i < WindowDepth; i++) begin
          window_r[s][i] <= '0;
        end
      end
    end else if (s1_fire) begin
      if (s1_kind_r == KIND_START) begin
        for (int s = 0; s < SENSOR_COUNT; s++) begin
          min_r[s] <= no_echo_r;
        end
      end else if (!s1_drop) begin
        slot_r[sidx] <= slot_nxt;
        min_r[sidx]  <= min_nxt;
        for (int i = 0; i < WindowDepth; i++) begin
          window_r[sidx][i] <= win_nxt[i];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_sensor_r <= s1_sid_r;
      if (s1_kind_r == KIND_START) begin
        out_qual_r     <= '0;
        out_filt_r     <= '0;
        out_min_r      <= no_echo_r;
        out_in_range_r <= 1'b0;
      end else begin
        out_qual_r     <= qual;
        out_filt_r     <= filt;
        out_min_r      <= min_nxt;
        out_in_range_r <= in_rng;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sensor          = out_sensor_r;
  assign out_qualified_cm    = out_qual_r;
  assign out_filtered_cm     = out_filt_r;
  assign out_interval_min_cm = out_min_r;
  assign out_in_range        = out_in_range_r;

endmodule
